### hw/rtl/assert_macros.svh
// Assertion macros shared by the link poll master RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define LPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define LPM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/lpm_pkg.sv
// Types, constants and frame byte tables of the link poll master.
package lpm_pkg;

  localparam int unsigned TIMER_BITS_DEF = 24;
  localparam int unsigned PERIOD_W       = 24;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned IDX_W          = 5;

  localparam logic [7:0]  BYTE_FIXED_START = 8'h10;
  localparam logic [7:0]  BYTE_VAR_START   = 8'h68;
  localparam logic [7:0]  BYTE_END         = 8'h16;
  localparam logic [7:0]  CTRL_BASE        = 8'h40;

  localparam logic [3:0]  CODE_LINK   = 4'd0;
  localparam logic [3:0]  CODE_DATA   = 4'd3;
  localparam logic [3:0]  CODE_CLASS1 = 4'd10;
  localparam logic [3:0]  CODE_CLASS2 = 4'd11;

  localparam logic [PERIOD_W-1:0] GI_PERIOD_RST    = 24'd1800;
  localparam logic [PERIOD_W-1:0] LINK_TIMEOUT_RST = 24'd50;
  localparam logic [PERIOD_W-1:0] MEASURE_RST      = 24'd7;
  localparam logic [7:0]          STATION_RST      = 8'd1;
  localparam logic [7:0]          GROUP_RST        = 8'd0;

  typedef enum logic [1:0] {
    FUNC_SEND = 2'd0,
    FUNC_RESP = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATION  = 3'd0,
    REG_GI       = 3'd1,
    REG_TIMEOUT  = 3'd2,
    REG_MEASURE  = 3'd3,
    REG_GROUP    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FRAME_FIXED = 2'd0,
    FRAME_GI    = 2'd1,
    FRAME_GR    = 2'd2
  } frame_kind_e;

  // One queued request frame, everything the serialiser needs.
  typedef struct packed {
    frame_kind_e kind;
    logic [7:0]  ctrl;
    logic [7:0]  addr;
    logic [7:0]  group;
  } frame_desc_t;

  function automatic logic [IDX_W-1:0] frame_last_idx(frame_kind_e kind);
    logic [IDX_W-1:0] r;
    unique case (kind)
      FRAME_FIXED: r = IDX_W'(4);
      FRAME_GI:    r = IDX_W'(14);
      FRAME_GR:    r = IDX_W'(18);
      default:     r = IDX_W'(4);
    endcase
    return r;
  endfunction

  // True for the bytes covered by the variable frame checksum.
  function automatic logic in_checksum(frame_kind_e kind, logic [IDX_W-1:0] idx);
    return (kind != FRAME_FIXED) && (idx >= IDX_W'(4)) &&
           (idx <= frame_last_idx(kind) - IDX_W'(2));
  endfunction

  function automatic logic [7:0] frame_byte(frame_desc_t d, logic [IDX_W-1:0] idx,
                                            logic [7:0] sum);
    logic [7:0] b;
    b = 8'h00;
    unique case (d.kind)
      FRAME_FIXED: begin
        unique case (idx)
          5'd0:    b = BYTE_FIXED_START;
          5'd1:    b = d.ctrl;
          5'd2:    b = d.addr;
          5'd3:    b = d.ctrl + d.addr;
          default: b = BYTE_END;
        endcase
      end
      FRAME_GI: begin
        unique case (idx)
          5'd0, 5'd3: b = BYTE_VAR_START;
          5'd1, 5'd2: b = 8'h09;
          5'd4:       b = d.ctrl;
          5'd5, 5'd9: b = d.addr;
          5'd6:       b = 8'h07;
          5'd7:       b = 8'h81;
          5'd8:       b = 8'h09;
          5'd10:      b = 8'hff;
          5'd13:      b = sum;
          5'd14:      b = BYTE_END;
          default:    b = 8'h00;
        endcase
      end
      FRAME_GR: begin
        unique case (idx)
          5'd0, 5'd3:  b = BYTE_VAR_START;
          5'd1, 5'd2:  b = 8'h0d;
          5'd4:        b = d.ctrl;
          5'd5, 5'd9:  b = d.addr;
          5'd6:        b = 8'h15;
          5'd7:        b = 8'h81;
          5'd8:        b = 8'h2a;
          5'd10:       b = 8'hfe;
          5'd11:       b = 8'hf1;
          5'd13, 5'd16: b = 8'h01;
          5'd14:       b = d.group;
          5'd17:       b = sum;
          5'd18:       b = BYTE_END;
          default:     b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/lpm_front.sv
// Request front end: link state, timers, configuration and frame selection.
module lpm_front #(
  parameter int unsigned TimerBits = lpm_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     func_i,
  input  logic                           frame_is_variable_i,
  input  logic [7:0]                     control_byte_i,
  input  logic                           cfg_valid_i,
  input  logic [lpm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lpm_pkg::PERIOD_W-1:0]   cfg_data_i,
  input  logic                           queue_full_i,
  output logic                           push_o,
  output lpm_pkg::frame_desc_t           push_desc_o
);

  localparam int unsigned CmpW = (TimerBits > lpm_pkg::PERIOD_W) ? TimerBits
                                                                 : lpm_pkg::PERIOD_W;

  typedef enum logic [2:0] {
    LS_RESET  = 3'd0,
    LS_STATUS = 3'd1,
    LS_CLASS1 = 3'd2,
    LS_CLASS2 = 3'd3,
    LS_GI     = 3'd4
  } link_state_e;

  link_state_e                  link_state_q, link_state_d;
  logic                         fcb_q, fcb_d;
  logic                         pending_q, pending_d;
  logic [TimerBits-1:0]         silence_q, silence_d;
  logic [TimerBits-1:0]         gi_age_q, gi_age_d;
  logic [TimerBits-1:0]         meas_age_q, meas_age_d;
  logic [7:0]                   station_q;
  logic [lpm_pkg::PERIOD_W-1:0] gi_period_q, timeout_q, measure_q;
  logic [7:0]                   group_q;
  logic                         accept;
  logic                         push_d;
  lpm_pkg::frame_kind_e         kind_d;
  logic                         fcv_d;
  logic [3:0]                   code_d;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    link_state_d = link_state_q;
    fcb_d        = fcb_q;
    pending_d    = pending_q;
    silence_d    = silence_q;
    gi_age_d     = gi_age_q;
    meas_age_d   = meas_age_q;
    push_d       = 1'b0;
    kind_d       = lpm_pkg::FRAME_FIXED;
    fcv_d        = 1'b0;
    code_d       = lpm_pkg::CODE_LINK;
    if (accept) begin
      unique case (lpm_pkg::func_e'(func_i))
        lpm_pkg::FUNC_SEND: begin
          unique case (link_state_q)
            LS_RESET: begin
              push_d = 1'b1;
            end
            LS_STATUS: begin
              push_d       = 1'b1;
              link_state_d = LS_GI;
              pending_d    = 1'b1;
            end
            LS_CLASS1: begin
              push_d = 1'b1;
              fcv_d  = 1'b1;
              code_d = lpm_pkg::CODE_CLASS1;
            end
            LS_CLASS2: begin
              push_d = 1'b1;
              fcv_d  = 1'b1;
              priority if (CmpW'(gi_age_q) > CmpW'(gi_period_q)) begin
                gi_age_d = '0;
                kind_d   = lpm_pkg::FRAME_GI;
                code_d   = lpm_pkg::CODE_DATA;
              end else if (pending_q) begin
                pending_d = 1'b0;
                kind_d    = lpm_pkg::FRAME_GI;
                code_d    = lpm_pkg::CODE_DATA;
              end else if (CmpW'(silence_q) > CmpW'(timeout_q)) begin
                fcv_d        = 1'b0;
                link_state_d = LS_GI;
                pending_d    = 1'b1;
              end else if (CmpW'(meas_age_q) > CmpW'(measure_q)) begin
                meas_age_d = '0;
                kind_d     = lpm_pkg::FRAME_GR;
                code_d     = lpm_pkg::CODE_DATA;
              end else begin
                code_d = lpm_pkg::CODE_CLASS2;
              end
            end
            LS_GI: begin
              push_d = 1'b1;
              kind_d = lpm_pkg::FRAME_GI;
              fcv_d  = 1'b1;
              code_d = lpm_pkg::CODE_DATA;
            end
            default: begin
              // Undefined link states send nothing.
              push_d = 1'b0;
            end
          endcase
        end
        lpm_pkg::FUNC_RESP: begin
          fcb_d     = !fcb_q;
          silence_d = '0;
          priority if (control_byte_i[5]) begin
            link_state_d = LS_CLASS1;
          end else if (!frame_is_variable_i && pending_q) begin
            pending_d    = 1'b0;
            link_state_d = LS_GI;
          end else begin
            link_state_d = LS_CLASS2;
          end
        end
        lpm_pkg::FUNC_TICK: begin
          silence_d  = (&silence_q)  ? silence_q  : silence_q  + 1'b1;
          gi_age_d   = (&gi_age_q)   ? gi_age_q   : gi_age_q   + 1'b1;
          meas_age_d = (&meas_age_q) ? meas_age_q : meas_age_q + 1'b1;
        end
        default: begin
          push_d = 1'b0;
        end
      endcase
    end
  end

  assign push_o            = push_d;
  assign push_desc_o.kind  = kind_d;
  assign push_desc_o.ctrl  = lpm_pkg::CTRL_BASE | {2'b00, fcb_q, fcv_d, code_d};
  assign push_desc_o.addr  = station_q;
  assign push_desc_o.group = group_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_state_q <= LS_STATUS;
      fcb_q        <= 1'b0;
      pending_q    <= 1'b0;
      silence_q    <= '0;
      gi_age_q     <= '0;
      meas_age_q   <= '0;
    end else begin
      link_state_q <= link_state_d;
      fcb_q        <= fcb_d;
      pending_q    <= pending_d;
      silence_q    <= silence_d;
      gi_age_q     <= gi_age_d;
      meas_age_q   <= meas_age_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q   <= lpm_pkg::STATION_RST;
      gi_period_q <= lpm_pkg::GI_PERIOD_RST;
      timeout_q   <= lpm_pkg::LINK_TIMEOUT_RST;
      measure_q   <= lpm_pkg::MEASURE_RST;
      group_q     <= lpm_pkg::GROUP_RST;
    end else if (cfg_valid_i) begin
      unique case (lpm_pkg::cfg_reg_e'(cfg_index_i))
        lpm_pkg::REG_STATION: station_q   <= cfg_data_i[7:0];
        lpm_pkg::REG_GI:      gi_period_q <= cfg_data_i;
        lpm_pkg::REG_TIMEOUT: timeout_q   <= cfg_data_i;
        lpm_pkg::REG_MEASURE: measure_q   <= cfg_data_i;
        lpm_pkg::REG_GROUP:   group_q     <= cfg_data_i[7:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

endmodule

### hw/rtl/lpm_queue.sv
// Short descriptor queue between the front end and the serialiser.
`include "assert_macros.svh"
module lpm_queue #(
  parameter int unsigned Depth = lpm_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lpm_pkg::frame_desc_t push_desc_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output lpm_pkg::frame_desc_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lpm_pkg::frame_desc_t mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `LPM_ASSERT(a_no_overflow, push_i |-> !full_o, "request pushed into a full queue")
  `LPM_ASSERT(a_no_underflow, pop_i |-> !empty_o, "request popped from an empty queue")
  `LPM_ASSERT(a_count_moves, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1),
              "queue fill count lost a push")

endmodule

### hw/rtl/lpm_back.sv
// Frame serialiser: turns one queued request into bytes, one per cycle unless stalled.
`include "assert_macros.svh"
module lpm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  lpm_pkg::frame_desc_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o
);

  lpm_pkg::frame_desc_t          desc_q;
  logic                          active_q;
  logic [lpm_pkg::IDX_W-1:0]     idx_q;
  logic [7:0]                    sum_q;
  logic                          out_valid_q;
  logic [7:0]                    out_byte_q;
  logic                          out_last_q;
  logic                          advance;
  logic [7:0]                    cur_byte;
  logic                          cur_last;

  assign advance  = !out_valid_q || out_ready_i;
  assign pop_o    = advance && !active_q && !empty_i;
  assign cur_byte = lpm_pkg::frame_byte(desc_q, idx_q, sum_q);
  assign cur_last = (idx_q == lpm_pkg::frame_last_idx(desc_q.kind));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      desc_q <= head_i;
    end
    if (advance && active_q) begin
      out_byte_q <= cur_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (advance) begin
      if (active_q) begin
        out_valid_q <= 1'b1;
        out_last_q  <= cur_last;
        idx_q       <= idx_q + 1'b1;
        if (lpm_pkg::in_checksum(desc_q.kind, idx_q)) begin
          sum_q <= sum_q + cur_byte;
        end
        if (cur_last) begin
          active_q <= 1'b0;
        end
      end else begin
        out_valid_q <= 1'b0;
        out_last_q  <= 1'b0;
        if (pop_o) begin
          active_q <= 1'b1;
          idx_q    <= '0;
          sum_q    <= '0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  `LPM_ASSERT(a_idx_in_frame, active_q |-> (idx_q <= lpm_pkg::frame_last_idx(desc_q.kind)),
              "byte index ran past the end of the frame")
  `LPM_ASSERT(a_last_ends_frame, (advance && active_q && cur_last) |=> !active_q,
              "serialiser stayed busy after the closing byte")
  `LPM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!out_valid_o && !active_q),
                     "serialiser busy during reset")

endmodule

### hw/rtl/link_poll_master.sv
// Link poll master top level: request front end, descriptor queue and serialiser.
// A send request passes the descriptor queue, the serialiser descriptor register and the
// output register before its first byte shows; frames (5, 15 or 19 bytes) go out one at
// a time; responses and ticks are taken one per cycle while the two-entry queue has room.
// Reset: asynchronous, active low; link state requests link status, timers and
// flags clear, registers return to their defaults and the output stream empties.
module link_poll_master #(
  parameter int unsigned TIMER_BITS = lpm_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] control_byte
  input  logic [2:0]                    s_axis_tuser_i,  // [1:0] func, [2] frame_is_variable
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o,  // [7:0] frame_byte
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lpm_pkg::PERIOD_W-1:0]  cfg_data_i
);

  logic                 queue_full;
  logic                 queue_empty;
  logic                 push;
  logic                 pop;
  lpm_pkg::frame_desc_t push_desc;
  lpm_pkg::frame_desc_t head_desc;

  assign cfg_ready_o = 1'b1;

  lpm_front #(
    .TimerBits (TIMER_BITS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (s_axis_tvalid_i),
    .in_ready_o          (s_axis_tready_o),
    .func_i              (s_axis_tuser_i[1:0]),
    .frame_is_variable_i (s_axis_tuser_i[2]),
    .control_byte_i      (s_axis_tdata_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .queue_full_i        (queue_full),
    .push_o              (push),
    .push_desc_o         (push_desc)
  );

  lpm_queue #(
    .Depth (lpm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (queue_full),
    .pop_i       (pop),
    .empty_o     (queue_empty),
    .head_o      (head_desc)
  );

  lpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (queue_empty),
    .head_i      (head_desc),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
